FILE: rtl/tyr_pkg.sv
// Package: shared types, constants and the pixel conversion function.
`timescale 1ns / 1ps
package tyr_pkg;

  localparam int TILE_DIM      = 16;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int ADDR_W        = 25;
  localparam int PADDR_W       = 5;

  // Register indexes of the configuration port (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_TILES_ACROSS = 3'd0,
    REG_BANDS_DOWN   = 3'd1,
    REG_WIN_WIDTH    = 3'd2,
    REG_WIN_HEIGHT   = 3'd3,
    REG_LINE_PITCH   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]  tiles_across;
    logic [8:0]  bands_down;
    logic [12:0] win_width;
    logic [12:0] win_height;
    logic [12:0] line_pitch;
  } cfg_t;

  // One classified row waiting for the back end.
  typedef struct packed {
    logic [127:0]        luma;
    logic [63:0]         cb;
    logic [63:0]         cr;
    logic [3:0]          last_idx;
    logic [7:0]          tile_col;
    logic [ADDR_W-1:0]   line_base;
  } row_t;

  // Floor of a 19-bit signed 11.8 value, clamped to 0..255.
  function automatic logic [7:0] clamp_chan(input logic signed [18:0] s);
    logic [7:0] res;
    if (s[18]) begin
      res = 8'd0;
    end else if (|s[17:16]) begin
      res = 8'hff;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  function automatic logic [23:0] yuv_to_rgb(input logic [7:0] y, input logic [7:0] cb,
                                             input logic [7:0] cr);
    logic signed [18:0] ys;
    logic signed [18:0] us;
    logic signed [18:0] vs;
    logic signed [18:0] rs;
    logic signed [18:0] gs;
    logic signed [18:0] bs;
    ys = $signed({3'b000, y, 8'h00});
    us = $signed({11'd0, cb}) - 19'sd128;
    vs = $signed({11'd0, cr}) - 19'sd128;
    rs = ys + 19'sd359 * vs;
    gs = ys - 19'sd88 * us - 19'sd183 * vs;
    bs = ys + 19'sd454 * us;
    return {clamp_chan(rs), clamp_chan(gs), clamp_chan(bs)};
  endfunction

endpackage

FILE: rtl/tyr_front.sv
// Front end: tile position counters, cropping and line address for each row.
`timescale 1ns / 1ps
module tyr_front import tyr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [63:0]  in_luma_left,
  input  logic [63:0]  in_luma_right,
  input  logic [63:0]  in_cb_row,
  input  logic [63:0]  in_cr_row,
  input  logic         q_full,
  output logic         q_push,
  output row_t         q_data
);

  localparam logic [13:0] MaxW = 14'(MAX_WIDTH);
  localparam logic [13:0] MaxH = 14'(MAX_HEIGHT);

  logic [7:0]  tile_col_r, tile_col_nxt;
  logic [3:0]  row_in_tile_r, row_in_tile_nxt;
  logic [7:0]  band_index_r, band_index_nxt;

  logic [13:0] w_eff, h_eff, stride_eff, col_base, rem;
  logic [11:0] line;
  logic [25:0] prod;
  logic [8:0]  tiles_lim, bands_lim, tc_inc, bi_inc;
  logic        accept, keep;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    w_eff      = ({1'b0, cfg.win_width} > MaxW) ? MaxW : {1'b0, cfg.win_width};
    h_eff      = ({1'b0, cfg.win_height} > MaxH) ? MaxH : {1'b0, cfg.win_height};
    stride_eff = (cfg.line_pitch == 13'd0) ? w_eff : {1'b0, cfg.line_pitch};
    line       = {band_index_r, row_in_tile_r};
    col_base   = {2'b00, tile_col_r, 4'h0};
    rem        = w_eff - col_base;
    keep       = ({2'b00, line} < h_eff) && (col_base < w_eff);
    prod       = line * stride_eff;

    q_push            = accept && keep;
    q_data.luma       = {in_luma_right, in_luma_left};
    q_data.cb         = in_cb_row;
    q_data.cr         = in_cr_row;
    q_data.last_idx   = (rem >= 14'd16) ? 4'hf : (rem[3:0] - 4'd1);
    q_data.tile_col   = tile_col_r;
    q_data.line_base  = prod[ADDR_W-1:0];
  end

  // Counter advance; zero counts behave as one, counts above 256 as 256.
  always_comb begin
    tiles_lim = (cfg.tiles_across == 9'd0) ? 9'd1 :
                (cfg.tiles_across > 9'd256) ? 9'd256 : cfg.tiles_across;
    bands_lim = (cfg.bands_down == 9'd0) ? 9'd1 :
                (cfg.bands_down > 9'd256) ? 9'd256 : cfg.bands_down;
    tc_inc    = {1'b0, tile_col_r} + 9'd1;
    bi_inc    = {1'b0, band_index_r} + 9'd1;
    tile_col_nxt    = tile_col_r;
    row_in_tile_nxt = row_in_tile_r;
    band_index_nxt  = band_index_r;
    if (accept) begin
      row_in_tile_nxt = row_in_tile_r + 4'd1;
      if (row_in_tile_r == 4'hf) begin
        if (tc_inc >= tiles_lim) begin
          tile_col_nxt = 8'd0;
          band_index_nxt = (bi_inc >= bands_lim) ? 8'd0 : bi_inc[7:0];
        end else begin
          tile_col_nxt = tc_inc[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_col_r    <= 8'd0;
      row_in_tile_r <= 4'd0;
      band_index_r  <= 8'd0;
    end else begin
      tile_col_r    <= tile_col_nxt;
      row_in_tile_r <= row_in_tile_nxt;
      band_index_r  <= band_index_nxt;
    end
  end

endmodule

FILE: rtl/tyr_queue.sv
// Two-entry queue of classified rows between the front and back ends.
`timescale 1ns / 1ps
module tyr_queue import tyr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  row_t push_data,
  output logic full,
  input  logic pop,
  output row_t pop_data,
  output logic empty
);

  row_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/tyr_back.sv
// Back end: converts kept row pixels into the output register, one per unstalled cycle.
`timescale 1ns / 1ps
module tyr_back import tyr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  row_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [23:0]       out_rgb,
  output logic [ADDR_W-1:0] out_dst_addr,
  output logic              out_last
);

  row_t              cur_r, cur_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              busy_r, busy_nxt;
  logic              valid_r, valid_nxt;
  logic [23:0]       rgb_r, rgb_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              last_r, last_nxt;

  logic              adv, fire, done;
  logic [7:0]        y_byte, cb_byte, cr_byte;

  assign adv   = !valid_r || out_ready;
  assign fire  = busy_r && adv;
  assign done  = fire && (idx_r == cur_r.last_idx);
  assign q_pop = !q_empty && (!busy_r || done);

  always_comb begin
    y_byte  = cur_r.luma[{idx_r, 3'b000} +: 8];
    cb_byte = cur_r.cb[{idx_r[3:1], 3'b000} +: 8];
    cr_byte = cur_r.cr[{idx_r[3:1], 3'b000} +: 8];

    cur_nxt  = q_pop ? q_data : cur_r;
    busy_nxt = q_pop ? 1'b1 : (done ? 1'b0 : busy_r);
    idx_nxt  = q_pop ? 4'd0 : (fire ? idx_r + 4'd1 : idx_r);

    valid_nxt = valid_r;
    rgb_nxt   = rgb_r;
    addr_nxt  = addr_r;
    last_nxt  = last_r;
    if (adv) begin
      valid_nxt = busy_r;
      rgb_nxt   = yuv_to_rgb(y_byte, cb_byte, cr_byte);
      addr_nxt  = cur_r.line_base + {{(ADDR_W-12){1'b0}}, cur_r.tile_col, idx_r};
      last_nxt  = (idx_r == cur_r.last_idx);
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rgb_r  <= rgb_nxt;
    addr_r <= addr_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= 4'd0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_rgb      = rgb_r;
  assign out_dst_addr = addr_r;
  assign out_last     = last_r;

endmodule

FILE: rtl/tiled_yuv420_to_rgb888_core.sv
// A row's pixels pass through the queue, the back end's row register and its output
// register. The back-end converter gives one pixel per cycle while out_ready holds,
// so a row with n kept pixels yields n pixels; a fully cropped row is accepted and
// produces nothing. A two-entry queue decouples the ends.
// Reset (synchronous, rst_n low): counters cleared, queue emptied, output invalid,
// configuration registers returned to their documented defaults.
`timescale 1ns / 1ps
module tiled_yuv420_to_rgb888_core import tyr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input item channel: one 16-pixel tile row with its chroma row.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_luma_left,
  input  logic [63:0]        in_luma_right,
  input  logic [63:0]        in_cb_row,
  input  logic [63:0]        in_cr_row,
  // Result channel: one converted pixel per transfer.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_rgb,
  output logic [ADDR_W-1:0]  out_dst_addr,
  output logic               out_last
);

  // Configuration registers live here; the front end reads them every cycle. Writes
  // must be made only while idle; the block does not enforce it. No shadowing needed.
  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  reg_idx_t   reg_sel;

  // Queue handshake between the front and back ends.
  logic       q_push, q_pop, q_full, q_empty;
  row_t       q_in, q_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  // Register decode: addresses beyond the list are ignored on write and read as zero.
  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = 32'd0;
    case (reg_sel)
      REG_TILES_ACROSS: begin
        prdata = {23'd0, cfg_r.tiles_across};
        if (cfg_wr) cfg_nxt.tiles_across = pwdata[8:0];
      end
      REG_BANDS_DOWN: begin
        prdata = {23'd0, cfg_r.bands_down};
        if (cfg_wr) cfg_nxt.bands_down = pwdata[8:0];
      end
      REG_WIN_WIDTH: begin
        prdata = {19'd0, cfg_r.win_width};
        if (cfg_wr) cfg_nxt.win_width = pwdata[12:0];
      end
      REG_WIN_HEIGHT: begin
        prdata = {19'd0, cfg_r.win_height};
        if (cfg_wr) cfg_nxt.win_height = pwdata[12:0];
      end
      REG_LINE_PITCH: begin
        prdata = {19'd0, cfg_r.line_pitch};
        if (cfg_wr) cfg_nxt.line_pitch = pwdata[12:0];
      end
      default: begin
        prdata = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tiles_across <= 9'd120;
      cfg_r.bands_down   <= 9'd68;
      cfg_r.win_width    <= 13'd1920;
      cfg_r.win_height   <= 13'd1080;
      cfg_r.line_pitch   <= 13'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end tracks the tile position, crops the row against the window and
  // computes the line's base address with a single multiply. Rows with no kept
  // pixel advance the counters but are not queued.
  tyr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_luma_left  (in_luma_left),
    .in_luma_right (in_luma_right),
    .in_cb_row     (in_cb_row),
    .in_cr_row     (in_cr_row),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  tyr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // The back end walks the kept pixels of each queued row and, unless out_ready
  // stalls it, converts one per cycle into its output register and takes the next row
  // as the last pixel of the current one is issued, so rows follow without a gap.
  tyr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rgb      (out_rgb),
    .out_dst_addr (out_dst_addr),
    .out_last     (out_last)
  );

endmodule

FILE: tb/sv/rgb_pixel_monitor.sv
// Pixel monitor: tracks the register writes, predicts every converted pixel and checks the output.
`timescale 1ns / 1ps
module rgb_pixel_monitor import tyr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [63:0]        luma_left,
  input  logic [63:0]        luma_right,
  input  logic [63:0]        cb_row,
  input  logic [63:0]        cr_row,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [23:0]        rgb,
  input  logic [ADDR_W-1:0]  dst_addr,
  input  logic               last,
  output int                 fail_count,
  output int                 pixels_outstanding
);

  typedef struct {
    logic [23:0]       rgb;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } pixel_t;

  pixel_t pixels_due[$];
  cfg_t   regs;
  int     tile_col;
  int     row_in_tile;
  int     band_idx;

  // Floor of a signed 24.8 value, saturated to one byte.
  function automatic logic [7:0] sat_channel(input int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'hff;
    return q[7:0];
  endfunction

  function automatic logic [23:0] pixel_rgb(input int y, input int u, input int v);
    return {sat_channel(256 * y + 359 * v),
            sat_channel(256 * y - 88 * u - 183 * v),
            sat_channel(256 * y + 454 * u)};
  endfunction

  // Tile and band counts of zero behave as one, anything above 256 as 256.
  function automatic int eff_count(input logic [8:0] n);
    if (n == 9'd0) return 1;
    if (n > 9'd256) return 256;
    return int'(n);
  endfunction

  function automatic void predict_tile_row(input logic [63:0] ll, input logic [63:0] lr,
                                           input logic [63:0] cb, input logic [63:0] cr);
    int w;
    int h;
    int stride;
    int line;
    int col;
    int keep_n;
    logic [63:0] lw;
    pixel_t px;
    w = (regs.win_width > 13'(MAX_WIDTH_DEF)) ? MAX_WIDTH_DEF : int'(regs.win_width);
    h = (regs.win_height > 13'(MAX_HEIGHT_DEF)) ? MAX_HEIGHT_DEF : int'(regs.win_height);
    stride = (regs.line_pitch == 13'd0) ? w : int'(regs.line_pitch);
    line = band_idx * TILE_DIM + row_in_tile;
    keep_n = w - tile_col * TILE_DIM;
    if (keep_n > TILE_DIM) keep_n = TILE_DIM;
    if (line < h) begin
      for (int i = 0; i < keep_n; i++) begin
        col = tile_col * TILE_DIM + i;
        lw = (i < 8) ? ll : lr;
        px.rgb = pixel_rgb(int'(lw[(i % 8) * 8 +: 8]),
                           int'(cb[(i / 2) * 8 +: 8]) - 128,
                           int'(cr[(i / 2) * 8 +: 8]) - 128);
        px.addr = ADDR_W'(line * stride + col);
        px.last = (i == keep_n - 1);
        pixels_due.push_back(px);
      end
    end
    // Rows advance first, then tiles across, then bands down.
    row_in_tile = (row_in_tile + 1) % TILE_DIM;
    if (row_in_tile == 0) begin
      tile_col++;
      if (tile_col >= eff_count(regs.tiles_across)) begin
        tile_col = 0;
        band_idx++;
        if (band_idx >= eff_count(regs.bands_down)) band_idx = 0;
      end
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      pixels_due.delete();
      regs.tiles_across = 9'd120;
      regs.bands_down   = 9'd68;
      regs.win_width    = 13'd1920;
      regs.win_height   = 13'd1080;
      regs.line_pitch   = 13'd0;
      tile_col    = 0;
      row_in_tile = 0;
      band_idx    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_TILES_ACROSS: regs.tiles_across = pwdata[8:0];
          REG_BANDS_DOWN:   regs.bands_down   = pwdata[8:0];
          REG_WIN_WIDTH:    regs.win_width    = pwdata[12:0];
          REG_WIN_HEIGHT:   regs.win_height   = pwdata[12:0];
          REG_LINE_PITCH:   regs.line_pitch   = pwdata[12:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel: rgb %h dst_addr %h last %b", rgb, dst_addr, last);
          fail_count++;
        end else begin
          want = pixels_due.pop_front();
          if (rgb !== want.rgb) begin
            $error("rgb: expected %h, actual %h", want.rgb, rgb);
            fail_count++;
          end
          if (dst_addr !== want.addr) begin
            $error("dst_addr: expected %h, actual %h", want.addr, dst_addr);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_tile_row(luma_left, luma_right, cb_row, cr_row);
    end
    pixels_outstanding = pixels_due.size();
  end

endmodule

FILE: tb/sv/tb_tiled_yuv420_to_rgb888_core.sv
// Testbench top: drives tile rows and register writes into the converter and gives the verdict.
`timescale 1ns / 1ps
module tb_tiled_yuv420_to_rgb888_core;
  import tyr_pkg::*;

  // Cycles without any accepted item, pixel or register write before the run is abandoned.
  localparam int STALL_LIMIT  = 2000;
  // Settling time after the last pixel, to cover rows that are still being cropped away.
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 24;
  // A register index one beyond the last mapped register.
  localparam int UNMAPPED_REG = 5;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [63:0]        in_luma_left = '0;
  logic [63:0]        in_luma_right = '0;
  logic [63:0]        in_cb_row = '0;
  logic [63:0]        in_cr_row = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [23:0]        out_rgb;
  logic [ADDR_W-1:0]  out_dst_addr;
  logic               out_last;

  int fail_count;
  int pixels_outstanding;
  int rows_sent = 0;
  int rx_idle_pct = 45;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tiled_yuv420_to_rgb888_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_luma_left (in_luma_left),
    .in_luma_right(in_luma_right),
    .in_cb_row    (in_cb_row),
    .in_cr_row    (in_cr_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rgb      (out_rgb),
    .out_dst_addr (out_dst_addr),
    .out_last     (out_last)
  );

  rgb_pixel_monitor pixel_mon (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .luma_left         (in_luma_left),
    .luma_right        (in_luma_right),
    .cb_row            (in_cb_row),
    .cr_row            (in_cr_row),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .rgb               (out_rgb),
    .dst_addr          (out_dst_addr),
    .last              (out_last),
    .fail_count        (fail_count),
    .pixels_outstanding(pixels_outstanding)
  );

  // The pixel sink stalls at random; its idle rate follows the stimulus phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // The watchdog restarts on any transfer, so a slow but live run is never cut short.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // A lane of random bytes, now and then all zeros or all ones to hit the clamping corners.
  function automatic logic [63:0] rand_lane();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Two-phase register write: a setup phase, then the access phase that completes on pready,
  // then the bus returns to idle.
  task automatic write_reg(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every predicted pixel has come out, then lets any fully cropped rows settle.
  task automatic wait_idle();
    while (pixels_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offers one tile row and holds it until the converter takes it. The first third of the
  // rows sees a bursty sender and a lazier sink, the second third the reverse, and the rest
  // runs flat out on both sides.
  task automatic send_row(input logic [63:0] ll, input logic [63:0] lr,
                          input logic [63:0] cb, input logic [63:0] cr);
    int tx_idle_pct;
    if (rows_sent < 104) begin
      tx_idle_pct = 31;
      rx_idle_pct <= 45;
    end else if (rows_sent < 208) begin
      tx_idle_pct = 45;
      rx_idle_pct <= 31;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_luma_left  <= ll;
    in_luma_right <= lr;
    in_cb_row     <= cb;
    in_cr_row     <= cr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rows_sent++;
    @(negedge clk);
  endtask

  // Reprograms the whole window while the converter is idle, then streams random rows.
  // With hold_midway set the sender stops half way until the last pixel has left.
  task automatic run_phase(input logic [31:0] tiles, input logic [31:0] bands,
                           input logic [31:0] width, input logic [31:0] height,
                           input logic [31:0] stride, input int rows, input bit hold_midway);
    in_valid <= 1'b0;
    wait_idle();
    write_reg(REG_TILES_ACROSS, tiles);
    write_reg(REG_BANDS_DOWN, bands);
    write_reg(REG_WIN_WIDTH, width);
    write_reg(REG_WIN_HEIGHT, height);
    write_reg(REG_LINE_PITCH, stride);
    for (int k = 0; k < rows; k++) begin
      if (hold_midway && k == rows / 2) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pixels_outstanding != 0) @(negedge clk);
      end
      send_row(rand_lane(), rand_lane(), rand_lane(), rand_lane());
    end
  endtask

  initial begin
    logic [63:0] ll;
    logic [63:0] lr;
    logic [63:0] cb;
    logic [63:0] cr;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A write beyond the register map must change nothing.
    write_reg(UNMAPPED_REG, 32'h0000_0001);

    // Directed rows under the reset window: the colour extremes, neutral chroma at both
    // luma ends, ramps and alternating bit patterns, then a few random rows to finish the
    // first tile.
    for (int k = 0; k < TILE_DIM; k++) begin
      case (k)
        0: begin
          ll = '0; lr = '0; cb = '0; cr = '0;
        end
        1: begin
          ll = '1; lr = '1; cb = '1; cr = '1;
        end
        2: begin
          ll = '1; lr = '1; cb = {8{8'h80}}; cr = {8{8'h80}};
        end
        3: begin
          ll = '0; lr = '0; cb = {8{8'h80}}; cr = {8{8'h80}};
        end
        4: begin
          ll = {8{8'h80}}; lr = {8{8'h80}}; cb = '0; cr = '1;
        end
        5: begin
          ll = {8{8'h80}}; lr = {8{8'h80}}; cb = '1; cr = '0;
        end
        6: begin
          ll = 64'h7060_5040_3020_1000;
          lr = 64'hf0e0_d0c0_b0a0_9080;
          cb = 64'hffe0_c0a0_8060_4020;
          cr = 64'h2040_6080_a0c0_e0ff;
        end
        7: begin
          ll = {16{4'h5}}; lr = {16{4'ha}}; cb = {16{4'ha}}; cr = {16{4'h5}};
        end
        default: begin
          ll = rand_lane(); lr = rand_lane(); cb = rand_lane(); cr = rand_lane();
        end
      endcase
      send_row(ll, lr, cb, cr);
    end

    // Small frame: cropping falls mid tile on the right and mid band at the bottom, and the
    // band counter wraps. The sender holds off half way through.
    run_phase(32'd2, 32'd3, 32'd20, 32'd40, 32'd0, 100, 1'b1);
    // Zero counts behave as one; a zero width keeps nothing at all.
    run_phase(32'd0, 32'd0, 32'd0, 32'd5, 32'd8191, 10, 1'b0);
    // Counts above range and an oversized window are clipped; a unit stride overlaps lines.
    run_phase(32'd511, 32'd300, 32'd8191, 32'd8191, 32'd1, 60, 1'b0);
    // Odd width splits a chroma pair, and only one line of the second band survives.
    run_phase(32'd1, 32'd2, 32'd9, 32'd17, 32'd13, 64, 1'b0);
    // Largest legal settings, with the widest stride.
    run_phase(32'd256, 32'd256, 32'd4096, 32'd4096, 32'd8191, 30, 1'b0);
    // Smallest window: a single pixel per frame of sixteen rows.
    run_phase(32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32, 1'b0);

    in_valid <= 1'b0;
    while (pixels_outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && pixels_outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tyr_pkg.sv
rtl/tyr_front.sv
rtl/tyr_queue.sv
rtl/tyr_back.sv
rtl/tiled_yuv420_to_rgb888_core.sv
tb/sv/rgb_pixel_monitor.sv
tb/sv/tb_tiled_yuv420_to_rgb888_core.sv
